@@ rtl/assert_macros.svh @@
// Assertion macros used by the clipper back end (pecl_back).
// Needs signals named clk and rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("immediate implication failed");
`define ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle implication failed");
`endif

@@ rtl/pecl_pkg.sv @@
// Package for the polygon edge line clipper: widths, payload types, codes,
// state types and the outcode function. No dependencies.
package pecl_pkg;
  localparam int CoordBits = 16;
  localparam int ProdBits = 2 * CoordBits + 2;
  localparam int DivCntW = $clog2(ProdBits + 1);
  localparam int MaxClips = 4;
  localparam int ClipCntW = $clog2(MaxClips + 1);
  localparam int EdgeQueueDepth = 2;
  localparam int ResultQueueDepth = 2;
  localparam int CfgAddrBits = 4;
  localparam int CfgDataBits = 32;

  localparam logic [1:0] RegWinLeft = 2'd0;
  localparam logic [1:0] RegWinBottom = 2'd1;
  localparam logic [1:0] RegWinRight = 2'd2;
  localparam logic [1:0] RegWinTop = 2'd3;

  localparam logic [3:0] OcLeft = 4'd1;
  localparam logic [3:0] OcRight = 4'd2;
  localparam logic [3:0] OcBottom = 4'd4;
  localparam logic [3:0] OcTop = 4'd8;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t vert_x;
    coord_t vert_y;
    logic closes_polygon;
  } vertex_t;

  typedef struct packed {
    coord_t seg_x0;
    coord_t seg_y0;
    coord_t seg_x1;
    coord_t seg_y1;
    logic run_end;
  } segment_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    logic last;
  } edge_t;

  typedef struct packed {
    coord_t left;
    coord_t bottom;
    coord_t right;
    coord_t top;
  } window_t;

  typedef enum logic [1:0] {F_IDLE, F_EDGE1, F_EDGE2} front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_CHECK, B_MUL, B_DIV, B_UPD, B_EMIT1, B_EMIT2
  } back_state_t;

  function automatic logic [3:0] outcode(coord_t x, coord_t y, window_t w);
    logic [3:0] c;
    c = 4'd0;
    if (x < w.left) begin
      c = c | OcLeft;
    end else if (x > w.right) begin
      c = c | OcRight;
    end
    if (y < w.bottom) begin
      c = c | OcBottom;
    end else if (y > w.top) begin
      c = c | OcTop;
    end
    return c;
  endfunction
endpackage

@@ rtl/pecl_queue.sv @@
// Small first-in first-out queue of registers for any packed payload type.
// Uses nothing from the package; DEPTH must be a power of two.
module pecl_queue #(
  parameter type T = logic [7:0],
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  T mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end
endmodule

@@ rtl/pecl_front.sv @@
// Front end: takes vertices, tracks the first and previous one, and issues the edge jobs
// from the previous vertex and, on a closing vertex, back to the first. Depends on pecl_pkg.
module pecl_front
  import pecl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  vertex_t vertex,
  output logic    edge_push,
  output edge_t   edge_data,
  input  logic    edge_full
);
  front_state_t state, state_next;
  coord_t start_x, start_y, prior_x, prior_y;
  logic have_start;
  logic closes;
  edge_t job1, job2;
  logic accept;

  assign accept = push && !full;

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept) begin
          if (have_start) begin
            state_next = F_EDGE1;
          end else if (vertex.closes_polygon) begin
            state_next = F_EDGE2;
          end
        end
      end
      F_EDGE1: begin
        if (!edge_full) begin
          state_next = closes ? F_EDGE2 : F_IDLE;
        end
      end
      F_EDGE2: begin
        if (!edge_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    full = 1'b1;
    edge_push = 1'b0;
    edge_data = job1;
    case (state)
      F_IDLE: full = 1'b0;
      F_EDGE1: edge_push = !edge_full;
      F_EDGE2: begin
        edge_push = !edge_full;
        edge_data = job2;
      end
      default: full = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      have_start <= 1'b0;
      start_x <= '0;
      start_y <= '0;
      prior_x <= '0;
      prior_y <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (!have_start) begin
          start_x <= vertex.vert_x;
          start_y <= vertex.vert_y;
        end
        prior_x <= vertex.vert_x;
        prior_y <= vertex.vert_y;
        have_start <= !vertex.closes_polygon;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      closes <= vertex.closes_polygon;
      job1 <= '{x0: prior_x, y0: prior_y, x1: vertex.vert_x, y1: vertex.vert_y,
                last: !vertex.closes_polygon};
      job2 <= '{x0: vertex.vert_x, y0: vertex.vert_y,
                x1: have_start ? start_x : vertex.vert_x,
                y1: have_start ? start_y : vertex.vert_y, last: 1'b1};
    end
  end
endmodule

@@ rtl/pecl_back.sv @@
// Back end: clips one edge at a time by Cohen-Sutherland iteration with a
// multiplier and a bit-serial divider, then emits the results. Depends on pecl_pkg.
module pecl_back
  import pecl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  window_t  win,
  input  logic     edge_empty,
  output logic     edge_pop,
  input  edge_t    edge_data,
  output logic     res_push,
  output segment_t res_data,
  input  logic     res_full
);
  `include "assert_macros.svh"

  localparam int W = CoordBits;

  back_state_t state, state_next;
  coord_t x0, y0, x1, y1;
  logic last;
  logic vis;
  logic [ClipCntW-1:0] nclip;
  segment_t pend;
  logic pend_valid;
  logic signed [W:0] op_a, op_b, op_d;
  logic clip_p0, clip_y;
  coord_t bound;
  logic [ProdBits-1:0] dq;
  logic [W:0] dmag;
  logic [W:0] rem;
  logic neg;
  logic [DivCntW-1:0] dcnt;

  logic [3:0] c0, c1, co;
  logic inv, acc, rej, decided;
  logic [W+1:0] rem_sh;
  logic rem_ge;
  logic [W:0] ua, ub, ud;
  logic [W:0] q;
  logic [W+1:0] qext, off, base_ext, newc;
  segment_t cur_seg;

  assign c0 = outcode(x0, y0, win);
  assign c1 = outcode(x1, y1, win);
  assign co = (c0 != 4'd0) ? c0 : c1;
  assign inv = (win.left > win.right) || (win.bottom > win.top);
  assign acc = !inv && ((c0 | c1) == 4'd0);
  assign rej = inv || ((c0 & c1) != 4'd0) || (nclip >= ClipCntW'(MaxClips));
  assign decided = acc || rej;

  assign ua = op_a[W] ? (W+1)'(-op_a) : op_a;
  assign ub = op_b[W] ? (W+1)'(-op_b) : op_b;
  assign ud = op_d[W] ? (W+1)'(-op_d) : op_d;

  assign rem_sh = {rem, dq[ProdBits-1]};
  assign rem_ge = rem_sh >= {1'b0, dmag};

  assign q = (dmag == '0) ? '0 : dq[W:0];
  assign qext = {1'b0, q};
  assign off = neg ? (W+2)'(-qext) : qext;
  assign base_ext = clip_y ? {{2{x0[W-1]}}, x0} : {{2{y0[W-1]}}, y0};
  assign newc = base_ext + off;

  assign cur_seg = '{seg_x0: x0, seg_y0: y0, seg_x1: x1, seg_y1: y1, run_end: 1'b1};

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (!edge_empty) state_next = B_CHECK;
      B_CHECK: begin
        if (decided) begin
          state_next = last ? B_EMIT1 : B_IDLE;
        end else begin
          state_next = B_MUL;
        end
      end
      B_MUL: state_next = B_DIV;
      B_DIV: if (dcnt == DivCntW'(1)) state_next = B_UPD;
      B_UPD: state_next = B_CHECK;
      B_EMIT1: if (!pend_valid || !res_full) state_next = B_EMIT2;
      B_EMIT2: if (!vis || !res_full) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    edge_pop = 1'b0;
    res_push = 1'b0;
    res_data = cur_seg;
    case (state)
      B_IDLE: edge_pop = !edge_empty;
      B_EMIT1: begin
        res_push = pend_valid && !res_full;
        res_data = pend;
        res_data.run_end = !vis;
      end
      B_EMIT2: res_push = vis && !res_full;
      default: edge_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_CHECK && decided && !last && acc) begin
        pend_valid <= 1'b1;
      end
      if (state == B_EMIT1 && res_push) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (edge_pop) begin
          x0 <= edge_data.x0;
          y0 <= edge_data.y0;
          x1 <= edge_data.x1;
          y1 <= edge_data.y1;
          last <= edge_data.last;
          nclip <= '0;
        end
      end
      B_CHECK: begin
        vis <= acc;
        if (decided && !last && acc) begin
          pend <= cur_seg;
        end
        clip_p0 <= (c0 != 4'd0);
        if ((co & OcTop) != 4'd0 || (co & OcBottom) != 4'd0) begin
          clip_y <= 1'b1;
          bound <= ((co & OcTop) != 4'd0) ? win.top : win.bottom;
          op_a <= $signed({x1[W-1], x1}) - $signed({x0[W-1], x0});
          op_b <= ((co & OcTop) != 4'd0)
                  ? $signed({win.top[W-1], win.top}) - $signed({y0[W-1], y0})
                  : $signed({win.bottom[W-1], win.bottom}) - $signed({y0[W-1], y0});
          op_d <= $signed({y1[W-1], y1}) - $signed({y0[W-1], y0});
        end else begin
          clip_y <= 1'b0;
          bound <= ((co & OcRight) != 4'd0) ? win.right : win.left;
          op_a <= $signed({y1[W-1], y1}) - $signed({y0[W-1], y0});
          op_b <= ((co & OcRight) != 4'd0)
                  ? $signed({win.right[W-1], win.right}) - $signed({x0[W-1], x0})
                  : $signed({win.left[W-1], win.left}) - $signed({x0[W-1], x0});
          op_d <= $signed({x1[W-1], x1}) - $signed({x0[W-1], x0});
        end
      end
      B_MUL: begin
        dq <= ProdBits'(ua) * ProdBits'(ub);
        dmag <= ud;
        neg <= op_a[W] ^ op_b[W] ^ op_d[W];
        rem <= '0;
        dcnt <= DivCntW'(ProdBits);
      end
      B_DIV: begin
        rem <= rem_ge ? (W+1)'(rem_sh - {1'b0, dmag}) : rem_sh[W:0];
        dq <= {dq[ProdBits-2:0], rem_ge};
        dcnt <= dcnt - 1'b1;
      end
      B_UPD: begin
        nclip <= nclip + 1'b1;
        if (clip_p0) begin
          x0 <= clip_y ? newc[W-1:0] : bound;
          y0 <= clip_y ? bound : newc[W-1:0];
        end else begin
          x1 <= clip_y ? newc[W-1:0] : bound;
          y1 <= clip_y ? bound : newc[W-1:0];
        end
      end
      default: nclip <= nclip;
    endcase
  end

  `ASSERT_IMP(a_clip_bound, state == B_CHECK, nclip <= ClipCntW'(MaxClips))
  `ASSERT_IMP(a_push_room, res_push, !res_full)
  `ASSERT_NXT(a_emit_done, (state == B_EMIT2) && (!vis || !res_full), state == B_IDLE)
endmodule

@@ rtl/polygon_edge_line_clipper.sv @@
// Polygon edge line clipper: vertices in, clipped visible segments out, with
// a Cohen-Sutherland clipper and window registers on an APB-style port.
// Depends on pecl_pkg, pecl_queue, pecl_front and pecl_back.
//
// Vertices are pushed one at a time, the last one of a polygon with
// closes_polygon set; each vertex after the first yields the edge from the
// previous vertex, and the closing vertex also yields the edge back to the
// first, so a vertex gives zero, one or two segments, the last of them
// flagged by run_end. Each endpoint clip runs through a multiplier and then a
// bit-serial divider in the clipping unit; an edge takes at most four clips
// and is rejected if it still lies partly outside after the fourth.
// Edges wait in a short queue so the vertex side can run ahead of the clipper
// until it fills. The window registers lie at byte addresses 0, 4, 8 and 12
// (left, bottom, right, top) and may be written only while the block is idle.
module polygon_edge_line_clipper
  import pecl_pkg::*;
#(
  parameter int EDGE_DEPTH = EdgeQueueDepth,
  parameter int RESULT_DEPTH = ResultQueueDepth
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  vertex_t                vertex,
  output logic                   empty,
  input  logic                   pop,
  output segment_t               segment,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CfgAddrBits-1:0] paddr,
  input  logic [CfgDataBits-1:0] pwdata,
  output logic [CfgDataBits-1:0] prdata,
  output logic                   pready
);
  window_t win;
  coord_t rd_val;
  logic cfg_wr;
  logic e_push, e_full, e_pop, e_empty;
  edge_t e_wdata, e_rdata;
  logic r_push, r_full;
  segment_t r_wdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      win.left <= coord_t'(0);
      win.bottom <= coord_t'(0);
      win.right <= coord_t'(799);
      win.top <= coord_t'(799);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegWinLeft: win.left <= pwdata[CoordBits-1:0];
        RegWinBottom: win.bottom <= pwdata[CoordBits-1:0];
        RegWinRight: win.right <= pwdata[CoordBits-1:0];
        RegWinTop: win.top <= pwdata[CoordBits-1:0];
        default: win <= win;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegWinLeft: rd_val = win.left;
      RegWinBottom: rd_val = win.bottom;
      RegWinRight: rd_val = win.right;
      RegWinTop: rd_val = win.top;
      default: rd_val = win.left;
    endcase
    prdata = {{(CfgDataBits-CoordBits){rd_val[CoordBits-1]}}, rd_val};
  end

  pecl_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .vertex(vertex),
    .edge_push(e_push), .edge_data(e_wdata), .edge_full(e_full)
  );

  pecl_queue #(.T(edge_t), .DEPTH(EDGE_DEPTH)) u_edge_q (
    .clk(clk), .rst(rst), .push(e_push), .wdata(e_wdata), .full(e_full),
    .pop(e_pop), .rdata(e_rdata), .empty(e_empty)
  );

  pecl_back u_back (
    .clk(clk), .rst(rst), .win(win), .edge_empty(e_empty), .edge_pop(e_pop),
    .edge_data(e_rdata), .res_push(r_push), .res_data(r_wdata), .res_full(r_full)
  );

  pecl_queue #(.T(segment_t), .DEPTH(RESULT_DEPTH)) u_res_q (
    .clk(clk), .rst(rst), .push(r_push), .wdata(r_wdata), .full(r_full),
    .pop(pop), .rdata(segment), .empty(empty)
  );
endmodule

@@ bench/polygon_edge_line_clipper_tb.sv @@
// Self-checking testbench for polygon_edge_line_clipper: drives vertices and
// window writes, predicts clipped segments and compares them in order.
// Depends on pecl_pkg and the polygon_edge_line_clipper RTL.
module polygon_edge_line_clipper_tb
  import pecl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst;
  logic push;
  logic full;
  vertex_t vertex;
  logic empty;
  logic pop;
  segment_t segment;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CfgAddrBits-1:0] paddr;
  logic [CfgDataBits-1:0] pwdata;
  logic [CfgDataBits-1:0] prdata;
  logic pready;

  polygon_edge_line_clipper uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .vertex(vertex),
    .empty(empty), .pop(pop), .segment(segment), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  vertex_t pending_vertices[$];
  segment_t expected_segments[$];
  window_t win;
  coord_t first_x, first_y, last_x, last_y;
  logic polygon_open;
  int send_idle_pct;
  int recv_stall_pct;
  int error_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic logic [3:0] region_code(longint x, longint y);
    logic [3:0] c;
    c = 4'd0;
    if (x < longint'(win.left)) begin
      c |= OcLeft;
    end else if (x > longint'(win.right)) begin
      c |= OcRight;
    end
    if (y < longint'(win.bottom)) begin
      c |= OcBottom;
    end else if (y > longint'(win.top)) begin
      c |= OcTop;
    end
    return c;
  endfunction

  // SystemVerilog signed division truncates toward zero, as required.
  function automatic longint scaled_offset(longint a, longint b, longint d);
    if (d == 0) begin
      return 0;
    end
    return (a * b) / d;
  endfunction

  function automatic logic clip_segment(input longint x0, input longint y0,
                                        input longint x1, input longint y1,
                                        output segment_t seg);
    logic [3:0] c0, c1, co;
    longint nx, ny;
    seg = '0;
    if (win.left > win.right || win.bottom > win.top) begin
      return 1'b0;
    end
    c0 = region_code(x0, y0);
    c1 = region_code(x1, y1);
    for (int n = 0; n <= MaxClips; n++) begin
      if ((c0 | c1) == 4'd0) begin
        break;
      end
      if ((c0 & c1) != 4'd0 || n >= MaxClips) begin
        return 1'b0;
      end
      co = (c0 != 4'd0) ? c0 : c1;
      if ((co & OcTop) != 0) begin
        nx = x0 + scaled_offset(x1 - x0, longint'(win.top) - y0, y1 - y0);
        ny = win.top;
      end else if ((co & OcBottom) != 0) begin
        nx = x0 + scaled_offset(x1 - x0, longint'(win.bottom) - y0, y1 - y0);
        ny = win.bottom;
      end else if ((co & OcRight) != 0) begin
        ny = y0 + scaled_offset(y1 - y0, longint'(win.right) - x0, x1 - x0);
        nx = win.right;
      end else begin
        ny = y0 + scaled_offset(y1 - y0, longint'(win.left) - x0, x1 - x0);
        nx = win.left;
      end
      if (co == c0) begin
        x0 = nx;
        y0 = ny;
        c0 = region_code(x0, y0);
      end else begin
        x1 = nx;
        y1 = ny;
        c1 = region_code(x1, y1);
      end
    end
    seg.seg_x0 = coord_t'(x0);
    seg.seg_y0 = coord_t'(y0);
    seg.seg_x1 = coord_t'(x1);
    seg.seg_y1 = coord_t'(y1);
    seg.run_end = 1'b0;
    return 1'b1;
  endfunction

  task automatic predict_vertex(input vertex_t v);
    segment_t s;
    int cnt;
    cnt = 0;
    if (!polygon_open) begin
      first_x = v.vert_x;
      first_y = v.vert_y;
      polygon_open = 1'b1;
    end else if (clip_segment(last_x, last_y, v.vert_x, v.vert_y, s)) begin
      expected_segments.push_back(s);
      cnt++;
    end
    last_x = v.vert_x;
    last_y = v.vert_y;
    if (v.closes_polygon) begin
      if (clip_segment(v.vert_x, v.vert_y, first_x, first_y, s)) begin
        expected_segments.push_back(s);
        cnt++;
      end
      polygon_open = 1'b0;
    end
    if (cnt > 0) begin
      expected_segments[$].run_end = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      vertex <= '0;
    end else begin
      if (push && !full) begin
        predict_vertex(vertex);
      end
      if (!push || !full) begin
        if (pending_vertices.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          vertex <= pending_vertices.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_segments.size() == 0) begin
          report_mismatch("unexpected segment", segment.seg_x0, 0);
        end else begin
          segment_t w;
          w = expected_segments.pop_front();
          if (segment.seg_x0 !== w.seg_x0) report_mismatch("seg_x0", segment.seg_x0, w.seg_x0);
          if (segment.seg_y0 !== w.seg_y0) report_mismatch("seg_y0", segment.seg_y0, w.seg_y0);
          if (segment.seg_x1 !== w.seg_x1) report_mismatch("seg_x1", segment.seg_x1, w.seg_x1);
          if (segment.seg_y1 !== w.seg_y1) report_mismatch("seg_y1", segment.seg_y1, w.seg_y1);
          if (segment.run_end !== w.run_end) report_mismatch("run_end", segment.run_end, w.run_end);
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_window(input logic [1:0] idx, input coord_t value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CfgAddrBits'(idx) << 2;
    pwdata <= CfgDataBits'(signed'(value));
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegWinLeft: win.left = value;
      RegWinBottom: win.bottom = value;
      RegWinRight: win.right = value;
      default: win.top = value;
    endcase
  endtask

  task automatic set_window(input coord_t l, input coord_t b, input coord_t r, input coord_t t);
    write_window(RegWinLeft, l);
    write_window(RegWinBottom, b);
    write_window(RegWinRight, r);
    write_window(RegWinTop, t);
  endtask

  task automatic wait_drained();
    while (pending_vertices.size() > 0 || push || expected_segments.size() > 0) begin
      @(posedge clk);
    end
    repeat (1000) @(posedge clk);
  endtask

  function automatic coord_t pick_coord(input coord_t lo, input coord_t hi);
    case ($urandom_range(9))
      0: return coord_t'($urandom);
      1: return 16'sh8000;
      2: return 16'sh7fff;
      3: return lo;
      4: return hi;
      default: return coord_t'(longint'(lo) - 40 +
                               longint'($urandom_range(32'(longint'(hi) - longint'(lo) + 80))));
    endcase
  endfunction

  task automatic queue_random_polygons(input int count);
    vertex_t v;
    int n;
    int queued;
    queued = 0;
    while (queued < count) begin
      n = ($urandom_range(9) == 0) ? 1 : $urandom_range(6, 2);
      for (int i = 0; i < n; i++) begin
        v.vert_x = pick_coord(win.left, win.right);
        v.vert_y = pick_coord(win.bottom, win.top);
        v.closes_polygon = (i == n - 1) || ($urandom_range(19) == 0);
        pending_vertices.push_back(v);
        queued++;
      end
    end
  endtask

  task automatic queue_vertex(input coord_t x, input coord_t y, input logic c);
    vertex_t v;
    v.vert_x = x;
    v.vert_y = y;
    v.closes_polygon = c;
    pending_vertices.push_back(v);
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    push = 1'b0;
    pop = 1'b0;
    vertex = '0;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    polygon_open = 1'b0;
    first_x = '0;
    first_y = '0;
    last_x = '0;
    last_y = '0;
    win.left = 16'sd0;
    win.bottom = 16'sd0;
    win.right = 16'sd799;
    win.top = 16'sd799;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset window, extremes, single-vertex polygons, crossings.
    queue_vertex(16'sd100, 16'sd100, 1'b1);
    queue_vertex(16'sh8000, 16'sh8000, 1'b1);
    queue_vertex(16'sh8000, 16'sh8000, 1'b0);
    queue_vertex(16'sh7fff, 16'sh7fff, 1'b0);
    queue_vertex(16'sh8000, 16'sh7fff, 1'b0);
    queue_vertex(16'sh7fff, 16'sh8000, 1'b1);
    queue_vertex(-16'sd50, 16'sd400, 1'b0);
    queue_vertex(16'sd900, 16'sd300, 1'b0);
    queue_vertex(16'sd400, 16'sd1000, 1'b0);
    queue_vertex(16'sd400, -16'sd5, 1'b1);
    queue_vertex(16'sd10, 16'sd10, 1'b0);
    queue_vertex(16'sd700, 16'sd20, 1'b0);
    queue_vertex(16'sd300, 16'sd790, 1'b1);
    queue_vertex(-16'sd100, 16'sd900, 1'b0);
    queue_vertex(16'sd900, -16'sd100, 1'b1);
    wait_drained();

    set_window(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    queue_vertex(16'sh8000, 16'sh7fff, 1'b0);
    queue_vertex(16'sh7fff, 16'sh8000, 1'b1);
    queue_random_polygons(60);
    wait_drained();

    set_window(16'sd100, 16'sd50, -16'sd100, 16'sd500);
    queue_vertex(16'sd0, 16'sd100, 1'b0);
    queue_vertex(16'sd10, 16'sd200, 1'b1);
    queue_random_polygons(15);
    wait_drained();

    send_idle_pct = 80;
    set_window(-16'sd300, -16'sd200, 16'sd250, 16'sd150);
    queue_random_polygons(110);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 80;
    set_window(16'sd0, 16'sd0, 16'sd799, 16'sd799);
    queue_random_polygons(110);
    wait_drained();

    send_idle_pct = 21;
    recv_stall_pct = 21;
    set_window(-16'sd20, -16'sd20, 16'sd20, 16'sd20);
    queue_random_polygons(110);
    wait_drained();

    if (error_count == 0) begin
      $display("polygon_edge_line_clipper regression: pass");
    end else begin
      $display("polygon_edge_line_clipper regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("polygon_edge_line_clipper regression: fail");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/pecl_pkg.sv
rtl/pecl_queue.sv
rtl/pecl_front.sv
rtl/pecl_back.sv
rtl/polygon_edge_line_clipper.sv
bench/polygon_edge_line_clipper_tb.sv
